>>> hdl/bce_pkg.sv
// shared types and constants for the bezier curve evaluator
package bce_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 15;
    localparam int KIND_WIDTH      = 3;
    localparam int PIPE_DEPTH      = 6;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_LINEAR      = 3'd0,
        KIND_QUAD_POINT  = 3'd1,
        KIND_QUAD_DERIV  = 3'd2,
        KIND_CUBIC_POINT = 3'd3,
        KIND_CUBIC_DERIV = 3'd4
    } t_kind;

endpackage

>>> hdl/bce_lane.sv
// one weight times operand lane with floor scaling, registered
module bce_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 15
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [T_FRAC_BITS+1:0]            i_w,
    input  logic signed [COORD_WIDTH:0]       i_q,
    output logic signed [COORD_WIDTH+3:0]     o_term
);

    localparam int WW    = T_FRAC_BITS + 2;
    localparam int QW    = COORD_WIDTH + 1;
    localparam int PRODW = WW + 1 + QW;
    localparam int TERMW = COORD_WIDTH + 4;

    logic signed [PRODW-1:0] prod;
    logic signed [TERMW-1:0] r_term;

    // upper bits of the two's complement product give the floor of the shift
    assign prod = $signed({1'b0, i_w}) * i_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= prod[T_FRAC_BITS +: TERMW];
        end
    end

    assign o_term = r_term;

endmodule

>>> hdl/bezier_curve_evaluator_top.sv
// bezier curve evaluator, one coordinate per word, six stage pipeline
// an accepted word moves through the stage registers in order, stage 1 to stage 6, to result valid
// throughput: one word per cycle while the output is not held; stages with no word take the next one
// while later stages wait, so a stall loses and repeats nothing
// the weight products and the four weight-by-point multipliers set the stage split
// reset (synchronous, active low) clears only the stage valid bits
module bezier_curve_evaluator_top
    import bce_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [KIND_WIDTH-1:0]         i_kind,
    input  logic [T_FRAC_BITS:0]          i_t_param,
    input  logic signed [COORD_WIDTH-1:0] i_point_a,
    input  logic signed [COORD_WIDTH-1:0] i_point_b,
    input  logic signed [COORD_WIDTH-1:0] i_point_c,
    input  logic signed [COORD_WIDTH-1:0] i_point_d,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH+2:0] o_coord_value
);

    localparam int TW    = T_FRAC_BITS + 1;
    localparam int WW    = T_FRAC_BITS + 2;
    localparam int PW    = 2 * T_FRAC_BITS + 2;
    localparam int QW    = COORD_WIDTH + 1;
    localparam int TERMW = COORD_WIDTH + 4;
    localparam int OW    = COORD_WIDTH + 3;
    localparam int NLANE = 4;
    localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    // stage valid bits and ready chain
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] rdy;
    logic [PIPE_DEPTH-1:0] vld_in;

    always_comb begin
        rdy[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || i_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        vld_in[0] = i_valid;
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_in[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[PIPE_DEPTH-1];

    // stage 1: saturate t, form u, pick operands per kind
    t_kind                kind_in;
    logic [TW-1:0]        t_sat;
    logic signed [QW-1:0] pa, pb, pc, pd;
    logic signed [QW-1:0] q_in [NLANE];

    t_kind                r1_kind;
    logic [TW-1:0]        r1_t, r1_u;
    logic signed [QW-1:0] r1_q [NLANE];

    assign kind_in = t_kind'(i_kind);
    assign t_sat   = (i_t_param > T_ONE) ? T_ONE : i_t_param;
    assign pa      = {i_point_a[COORD_WIDTH-1], i_point_a};
    assign pb      = {i_point_b[COORD_WIDTH-1], i_point_b};
    assign pc      = {i_point_c[COORD_WIDTH-1], i_point_c};
    assign pd      = {i_point_d[COORD_WIDTH-1], i_point_d};

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            q_in[j] = '0;
        end
        unique case (kind_in)
            KIND_LINEAR: begin
                q_in[0] = pa;
                q_in[1] = pb;
            end
            KIND_QUAD_POINT: begin
                q_in[0] = pa;
                q_in[1] = pb;
                q_in[2] = pc;
            end
            KIND_QUAD_DERIV: begin
                q_in[0] = pb - pa;
                q_in[1] = pc - pb;
            end
            KIND_CUBIC_POINT: begin
                q_in[0] = pa;
                q_in[1] = pb;
                q_in[2] = pc;
                q_in[3] = pd;
            end
            KIND_CUBIC_DERIV: begin
                q_in[0] = pb - pa;
                q_in[1] = pc - pb;
                q_in[2] = pd - pc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_kind <= kind_in;
            r1_t    <= t_sat;
            r1_u    <= T_ONE - t_sat;
            for (int j = 0; j < NLANE; j++) begin
                r1_q[j] <= q_in[j];
            end
        end
    end

    // stage 2: squares and cross product of t and u
    t_kind                r2_kind;
    logic [TW-1:0]        r2_t, r2_u;
    logic [PW-1:0]        r2_uu, r2_tt, r2_ut;
    logic signed [QW-1:0] r2_q [NLANE];

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r2_kind <= r1_kind;
            r2_t    <= r1_t;
            r2_u    <= r1_u;
            r2_uu   <= r1_u * r1_u;
            r2_tt   <= r1_t * r1_t;
            r2_ut   <= r1_u * r1_t;
            r2_q    <= r1_q;
        end
    end

    // stage 3: cubic products from the scaled squares
    logic [TW-1:0]        u2_s3, t2_s3;
    t_kind                r3_kind;
    logic [TW-1:0]        r3_t, r3_u;
    logic [PW-1:0]        r3_uu, r3_tt, r3_ut;
    logic [PW-1:0]        r3_uuu, r3_uut, r3_utt, r3_ttt;
    logic signed [QW-1:0] r3_q [NLANE];

    assign u2_s3 = r2_uu[T_FRAC_BITS +: TW];
    assign t2_s3 = r2_tt[T_FRAC_BITS +: TW];

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r3_kind <= r2_kind;
            r3_t    <= r2_t;
            r3_u    <= r2_u;
            r3_uu   <= r2_uu;
            r3_tt   <= r2_tt;
            r3_ut   <= r2_ut;
            r3_uuu  <= u2_s3 * r2_u;
            r3_uut  <= u2_s3 * r2_t;
            r3_utt  <= r2_u * t2_s3;
            r3_ttt  <= t2_s3 * r2_t;
            r3_q    <= r2_q;
        end
    end

    // stage 4: weight select per kind
    function automatic logic [PW+1:0] times3(input logic [PW-1:0] x);
        times3 = {1'b0, x, 1'b0} + {2'b00, x};
    endfunction

    logic [PW+1:0]        x3_uu, x3_tt, x3_ut, x3_uut, x3_utt;
    logic [WW-1:0]        w_sel [NLANE];
    logic [WW-1:0]        r4_w [NLANE];
    logic signed [QW-1:0] r4_q [NLANE];

    assign x3_uu  = times3(r3_uu);
    assign x3_tt  = times3(r3_tt);
    assign x3_ut  = times3(r3_ut);
    assign x3_uut = times3(r3_uut);
    assign x3_utt = times3(r3_utt);

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            w_sel[j] = '0;
        end
        unique case (r3_kind)
            KIND_LINEAR: begin
                w_sel[0] = {1'b0, r3_u};
                w_sel[1] = {1'b0, r3_t};
            end
            KIND_QUAD_POINT: begin
                w_sel[0] = {1'b0, r3_uu[T_FRAC_BITS +: TW]};
                w_sel[1] = r3_ut[T_FRAC_BITS-1 +: WW];
                w_sel[2] = {1'b0, r3_tt[T_FRAC_BITS +: TW]};
            end
            KIND_QUAD_DERIV: begin
                w_sel[0] = {r3_u, 1'b0};
                w_sel[1] = {r3_t, 1'b0};
            end
            KIND_CUBIC_POINT: begin
                w_sel[0] = r3_uuu[T_FRAC_BITS +: WW];
                w_sel[1] = x3_uut[T_FRAC_BITS +: WW];
                w_sel[2] = x3_utt[T_FRAC_BITS +: WW];
                w_sel[3] = r3_ttt[T_FRAC_BITS +: WW];
            end
            KIND_CUBIC_DERIV: begin
                w_sel[0] = x3_uu[T_FRAC_BITS +: WW];
                w_sel[1] = x3_ut[T_FRAC_BITS-1 +: WW];
                w_sel[2] = x3_tt[T_FRAC_BITS +: WW];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r4_w <= w_sel;
            r4_q <= r3_q;
        end
    end

    // stage 5: weight by operand lanes
    logic signed [TERMW-1:0] term [NLANE];

    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        bce_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .T_FRAC_BITS (T_FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (rdy[4]),
            .i_w    (r4_w[g]),
            .i_q    (r4_q[g]),
            .o_term (term[g])
        );
    end

    // stage 6: sum of terms into the output register
    logic signed [TERMW-1:0] sum;
    logic signed [OW-1:0]    r6_out;

    assign sum = term[0] + term[1] + term[2] + term[3];

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r6_out <= sum[OW-1:0];
        end
    end

    assign o_coord_value = r6_out;

endmodule

>>> hdl/bce_checker.sv
// port level checks for the bezier curve evaluator and their bind
module bce_checker
    import bce_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [KIND_WIDTH-1:0]         i_kind,
    input logic [T_FRAC_BITS:0]          i_t_param,
    input logic signed [COORD_WIDTH-1:0] i_point_a,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [COORD_WIDTH+2:0] o_coord_value
);

    localparam int OW = COORD_WIDTH + 3;

    logic in_acc;
    assign in_acc = i_valid && o_ready;

    // no word comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a held word stays unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_coord_value))
        else $error("output word changed while stalled");

    // an output that starts from empty was accepted one full latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(in_acc, PIPE_DEPTH))
        else $error("output word without matching input");

    // unknown kinds give zero
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && $past(in_acc, PIPE_DEPTH)
            && ($past(i_kind, PIPE_DEPTH) > KIND_CUBIC_DERIV)
        |-> o_coord_value == '0)
        else $error("unknown kind gave nonzero result");

    // linear at t of zero returns the first point
    a_linear_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && $past(in_acc, PIPE_DEPTH)
            && ($past(i_kind, PIPE_DEPTH) == KIND_LINEAR)
            && ($past(i_t_param, PIPE_DEPTH) == '0)
        |-> o_coord_value == OW'($past(i_point_a, PIPE_DEPTH)))
        else $error("linear at start differs from first point");

endmodule

bind bezier_curve_evaluator_top bce_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
) u_bce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_kind        (i_kind),
    .i_t_param     (i_t_param),
    .i_point_a     (i_point_a),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_coord_value (o_coord_value)
);

>>> dv/bezier_coord_checker.sv
`timescale 1ns / 100ps
// checker for the bezier curve evaluator: predicts each coordinate and compares results
module bezier_coord_checker
    import bce_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [KIND_WIDTH-1:0]             i_kind,
    input  logic [T_FRAC_BITS_DEF:0]          i_t_param,
    input  logic signed [COORD_WIDTH_DEF-1:0] i_point_a,
    input  logic signed [COORD_WIDTH_DEF-1:0] i_point_b,
    input  logic signed [COORD_WIDTH_DEF-1:0] i_point_c,
    input  logic signed [COORD_WIDTH_DEF-1:0] i_point_d,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [COORD_WIDTH_DEF+2:0] i_coord_value,
    output int                                o_pending_words,
    output int                                o_mismatch_count
);

    localparam int    VALUE_WIDTH = COORD_WIDTH_DEF + 3;
    localparam longint T_UNITY    = longint'(1) << T_FRAC_BITS_DEF;

    typedef logic signed [VALUE_WIDTH-1:0] t_coord_value;

    t_coord_value expected_coords[$];
    int           mismatches;

    // floor(w * p / 2^F), exact in 64 bits for these widths
    function automatic longint weigh_point(longint weight, longint point);
        longint prod;
        prod = weight * point;
        return prod >>> T_FRAC_BITS_DEF;
    endfunction

    function automatic t_coord_value predict_coord(
        logic [KIND_WIDTH-1:0]             kind,
        logic [T_FRAC_BITS_DEF:0]          t_raw,
        logic signed [COORD_WIDTH_DEF-1:0] pa,
        logic signed [COORD_WIDTH_DEF-1:0] pb,
        logic signed [COORD_WIDTH_DEF-1:0] pc,
        logic signed [COORD_WIDTH_DEF-1:0] pd
    );
        longint tv, uv, u_sq, t_sq, p0, p1, p2, p3, acc;
        tv   = (longint'(t_raw) > T_UNITY) ? T_UNITY : longint'(t_raw);
        uv   = T_UNITY - tv;
        u_sq = (uv * uv) >> T_FRAC_BITS_DEF;
        t_sq = (tv * tv) >> T_FRAC_BITS_DEF;
        p0   = pa;
        p1   = pb;
        p2   = pc;
        p3   = pd;
        case (kind)
            KIND_LINEAR: begin
                acc = weigh_point(uv, p0) + weigh_point(tv, p1);
            end
            KIND_QUAD_POINT: begin
                acc = weigh_point(u_sq, p0)
                    + weigh_point((2 * uv * tv) >> T_FRAC_BITS_DEF, p1)
                    + weigh_point(t_sq, p2);
            end
            KIND_QUAD_DERIV: begin
                acc = weigh_point(2 * uv, p1 - p0) + weigh_point(2 * tv, p2 - p1);
            end
            KIND_CUBIC_POINT: begin
                acc = weigh_point((u_sq * uv) >> T_FRAC_BITS_DEF, p0)
                    + weigh_point((3 * u_sq * tv) >> T_FRAC_BITS_DEF, p1)
                    + weigh_point((3 * uv * t_sq) >> T_FRAC_BITS_DEF, p2)
                    + weigh_point((t_sq * tv) >> T_FRAC_BITS_DEF, p3);
            end
            KIND_CUBIC_DERIV: begin
                acc = weigh_point((3 * uv * uv) >> T_FRAC_BITS_DEF, p1 - p0)
                    + weigh_point((6 * uv * tv) >> T_FRAC_BITS_DEF, p2 - p1)
                    + weigh_point((3 * tv * tv) >> T_FRAC_BITS_DEF, p3 - p2);
            end
            default: begin
                acc = 0;
            end
        endcase
        return acc[VALUE_WIDTH-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_coord_value want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                expected_coords.push_back(predict_coord(i_kind, i_t_param, i_point_a,
                                                        i_point_b, i_point_c, i_point_d));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_coords.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, coord_value actual %0d",
                             $time, i_coord_value);
                end else begin
                    want = expected_coords.pop_front();
                    if (i_coord_value !== want) begin
                        mismatches++;
                        $display("%0t: coord_value mismatch, expected %0d actual %0d",
                                 $time, want, i_coord_value);
                    end
                end
            end
            o_pending_words  <= expected_coords.size();
            o_mismatch_count <= mismatches;
        end
    end

endmodule

>>> dv/tb_bezier_curve_evaluator_top.sv
`timescale 1ns / 100ps
// testbench top for the bezier curve evaluator: stimulus, idling, watchdog and verdict
module tb_bezier_curve_evaluator_top;
    import bce_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_WORDS = 150;
    localparam int T_UNITY      = 1 << T_FRAC_BITS_DEF;

    typedef logic [T_FRAC_BITS_DEF:0] t_tparam;

    localparam logic signed [COORD_WIDTH_DEF-1:0] COORD_MAX =
        {1'b0, {(COORD_WIDTH_DEF-1){1'b1}}};
    localparam logic signed [COORD_WIDTH_DEF-1:0] COORD_MIN =
        {1'b1, {(COORD_WIDTH_DEF-1){1'b0}}};

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic [KIND_WIDTH-1:0]             i_kind;
    logic [T_FRAC_BITS_DEF:0]          i_t_param;
    logic signed [COORD_WIDTH_DEF-1:0] i_point_a;
    logic signed [COORD_WIDTH_DEF-1:0] i_point_b;
    logic signed [COORD_WIDTH_DEF-1:0] i_point_c;
    logic signed [COORD_WIDTH_DEF-1:0] i_point_d;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [COORD_WIDTH_DEF+2:0] o_coord_value;

    int pending_words;
    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    bezier_curve_evaluator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_t_param     (i_t_param),
        .i_point_a     (i_point_a),
        .i_point_b     (i_point_b),
        .i_point_c     (i_point_c),
        .i_point_d     (i_point_d),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_coord_value (o_coord_value)
    );

    bezier_coord_checker coord_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_kind           (i_kind),
        .i_t_param        (i_t_param),
        .i_point_a        (i_point_a),
        .i_point_b        (i_point_b),
        .i_point_c        (i_point_c),
        .i_point_d        (i_point_d),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_coord_value    (o_coord_value),
        .o_pending_words  (pending_words),
        .o_mismatch_count (mismatch_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic present_word(
        input logic [KIND_WIDTH-1:0]             kind,
        input logic [T_FRAC_BITS_DEF:0]          t_param,
        input logic signed [COORD_WIDTH_DEF-1:0] pa,
        input logic signed [COORD_WIDTH_DEF-1:0] pb,
        input logic signed [COORD_WIDTH_DEF-1:0] pc,
        input logic signed [COORD_WIDTH_DEF-1:0] pd
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_t_param <= t_param;
        i_point_a <= pa;
        i_point_b <= pb;
        i_point_c <= pc;
        i_point_d <= pd;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic signed [COORD_WIDTH_DEF-1:0] random_point();
        case ($urandom_range(15))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [T_FRAC_BITS_DEF:0] random_t();
        case ($urandom_range(9))
            0:       return t_tparam'($urandom_range(2**(T_FRAC_BITS_DEF+1) - 1, T_UNITY + 1));
            1:       return ($urandom_range(1) != 0) ? t_tparam'(T_UNITY) : '0;
            default: return t_tparam'($urandom_range(T_UNITY, 0));
        endcase
    endfunction

    function automatic logic [KIND_WIDTH-1:0] random_kind();
        if ($urandom_range(9) == 0) begin
            return KIND_WIDTH'($urandom_range(2**KIND_WIDTH - 1, KIND_CUBIC_DERIV + 1));
        end
        return KIND_WIDTH'($urandom_range(KIND_CUBIC_DERIV, KIND_LINEAR));
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = '0;
        i_t_param     = '0;
        i_point_a     = '0;
        i_point_b     = '0;
        i_point_c     = '0;
        i_point_d     = '0;
        send_idle_pct = 30;
        recv_idle_pct = 69;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: every kind at both ends of t and mid-curve
        for (int k = KIND_LINEAR; k <= KIND_CUBIC_DERIV; k++) begin
            present_word(KIND_WIDTH'(k), '0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
            present_word(KIND_WIDTH'(k), t_tparam'(T_UNITY), COORD_MIN, COORD_MAX,
                         COORD_MIN, COORD_MAX);
            present_word(KIND_WIDTH'(k), t_tparam'(T_UNITY / 2), COORD_MIN, COORD_MIN,
                         COORD_MIN, COORD_MIN);
        end
        // t beyond one saturates
        present_word(KIND_CUBIC_POINT, '1, COORD_MAX, COORD_MIN, '0, COORD_MAX);
        present_word(KIND_QUAD_DERIV, t_tparam'(T_UNITY + 1), COORD_MIN, COORD_MAX,
                     COORD_MIN, '1);
        // unsupported kinds read as zero
        for (int k = KIND_CUBIC_DERIV + 1; k < 2**KIND_WIDTH; k++) begin
            present_word(KIND_WIDTH'(k), random_t(), random_point(), random_point(),
                         random_point(), random_point());
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 30; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            repeat (RANDOM_WORDS) begin
                present_word(random_kind(), random_t(), random_point(), random_point(),
                             random_point(), random_point());
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending_words != 0);
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/bce_pkg.sv
hdl/bce_lane.sv
hdl/bezier_curve_evaluator_top.sv
hdl/bce_checker.sv
dv/bezier_coord_checker.sv
dv/tb_bezier_curve_evaluator_top.sv
